FILE: src/rpcc_pkg.sv
// ----------------------------------------------------------------------------
// rpcc_pkg: shared types and constants
// Action and status codes, table size and the queued item format.
// ----------------------------------------------------------------------------
package rpcc_pkg;

  localparam int TableEntries = 16;
  localparam int SlotW = $clog2(TableEntries);

  typedef enum logic [2:0] {
    ACT_WRITE   = 3'd0,
    ACT_FREE    = 3'd1,
    ACT_DELIVER = 3'd2,
    ACT_CHECK   = 3'd3,
    ACT_RELEASE = 3'd4
  } action_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_MATCH  = 3'd1;
  localparam logic [2:0] ST_UNWANTED  = 3'd2;
  localparam logic [2:0] ST_NO_SPACE  = 3'd3;
  localparam logic [2:0] ST_BAD_RANGE = 3'd4;
  localparam logic [2:0] ST_IN_USE    = 3'd5;

  localparam logic [0:0] CFG_RES_PROTO = 1'd0;
  localparam logic [0:0] CFG_RES_LINK  = 1'd1;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [1:0]  kind_mask;
    logic [1:0]  options;
    logic [7:0]  low_number;
    logic [7:0]  high_number;
    logic [31:0] host_addr;
    logic [31:0] peer_addr;
    logic [31:0] local_addr;
    logic [1:0]  packet_flags;
    logic [3:0]  interface_id;
    logic [7:0]  buffer_count;
    logic        bad_range;
  } item_t;

  typedef struct packed {
    logic   valid;
    logic   ready;
  } qctl_t;

endpackage

FILE: src/rpcc_front.sv
// ----------------------------------------------------------------------------
// rpcc_front: item intake and classification
// Registers configuration, accepts items, flags bad ranges and queues them.
// ----------------------------------------------------------------------------
module rpcc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 space,
  output logic                 take,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [2:0]           action,
  input  logic [3:0]           slot,
  input  logic [1:0]           kind_mask,
  input  logic [1:0]           options,
  input  logic [7:0]           low_number,
  input  logic [7:0]           high_number,
  input  logic [31:0]          host_addr,
  input  logic [31:0]          peer_addr,
  input  logic [31:0]          local_addr,
  input  logic [1:0]           packet_flags,
  input  logic [3:0]           interface_id,
  input  logic [7:0]           buffer_count,
  output rpcc_pkg::item_t      item
);

  logic [7:0] reserved_protocol;
  logic [7:0] reserved_link;
  logic       bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_protocol <= 8'd6;
      reserved_link     <= 8'd155;
    end else if (cfg_valid) begin
      if (cfg_index == rpcc_pkg::CFG_RES_PROTO) reserved_protocol <= cfg_data;
      else reserved_link <= cfg_data;
    end
  end

  assign take = start && space;

  always_comb begin
    bad = (high_number < low_number) ||
          (kind_mask == 2'd1 && low_number <= reserved_protocol &&
           high_number >= reserved_protocol) ||
          (kind_mask == 2'd2 && low_number <= reserved_link &&
           high_number >= reserved_link);
    item = '{action, slot, kind_mask, options, low_number, high_number,
             host_addr, peer_addr, local_addr, packet_flags, interface_id,
             buffer_count, bad};
  end

endmodule

FILE: src/rpcc_queue.sv
// ----------------------------------------------------------------------------
// rpcc_queue: two-entry item queue
// Decouples intake from the table engine.
// ----------------------------------------------------------------------------
module rpcc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rpcc_pkg::item_t push_item,
  output logic            space,
  input  logic            pop,
  output rpcc_pkg::qctl_t ctl,
  output rpcc_pkg::item_t head
);

  rpcc_pkg::item_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign space     = (fill != 2'd2);
  assign ctl.valid = (fill != 2'd0);
  assign ctl.ready = space;
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: src/rpcc_back.sv
// ----------------------------------------------------------------------------
// rpcc_back: connection table engine
// Holds the table, scans one entry a cycle and issues one result per item.
// ----------------------------------------------------------------------------
module rpcc_back (
  input  logic            clk,
  input  logic            rst,
  input  rpcc_pkg::qctl_t ctl,
  input  rpcc_pkg::item_t head,
  output logic            pop,
  output logic            done,
  output logic [2:0]      status,
  output logic [3:0]      matched_slot,
  output logic [7:0]      buffers_in_use,
  output logic [15:0]     drop_total
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  localparam int SW = rpcc_pkg::SlotW;

  state_t state, state_next;
  rpcc_pkg::item_t cur;
  logic [SW-1:0] idx;
  logic          found;
  logic [SW-1:0] hit;

  logic [rpcc_pkg::TableEntries-1:0] ev;
  logic [1:0]  ekind [rpcc_pkg::TableEntries];
  logic [1:0]  eopt  [rpcc_pkg::TableEntries];
  logic [7:0]  elow  [rpcc_pkg::TableEntries];
  logic [7:0]  ehigh [rpcc_pkg::TableEntries];
  logic [31:0] ehost [rpcc_pkg::TableEntries];
  logic [31:0] eaddr [rpcc_pkg::TableEntries];
  logic [3:0]  eifid [rpcc_pkg::TableEntries];
  logic [7:0]  ecap  [rpcc_pkg::TableEntries];
  logic [7:0]  eused [rpcc_pkg::TableEntries];
  logic [15:0] drops;

  logic dlv_hit, chk_hit, hit_now;
  logic [SW-1:0] s;
  logic          slot_ok;
  logic [8:0]    sum;

  assign s       = cur.slot[SW-1:0];
  assign slot_ok = ({1'b0, cur.slot} < 5'(rpcc_pkg::TableEntries));
  assign sum     = 9'(cur.buffer_count) + 9'(eused[hit]);

  always_comb begin
    dlv_hit = ev[idx] && (ekind[idx] & cur.kind_mask) != 2'd0 &&
              elow[idx] <= cur.low_number && ehigh[idx] >= cur.low_number &&
              (ehost[idx] == 32'd0 || ehost[idx] == cur.host_addr) &&
              (eopt[idx][0] ||
               (!cur.packet_flags[0] && eifid[idx] == cur.interface_id) ||
               (cur.packet_flags[0] && eaddr[idx] == cur.local_addr));
    chk_hit = ev[idx] && (ekind[idx] & cur.kind_mask) != 2'd0 &&
              ((elow[idx] <= cur.low_number && ehigh[idx] >= cur.low_number) ||
               (elow[idx] <= cur.high_number && ehigh[idx] >= cur.high_number) ||
               (elow[idx] >= cur.low_number && ehigh[idx] <= cur.high_number)) &&
              (ehost[idx] == 32'd0 || cur.host_addr == 32'd0 ||
               ehost[idx] == cur.peer_addr) &&
              (eopt[idx][0] || cur.options[0] || eaddr[idx] == cur.local_addr);
    hit_now = (cur.action == rpcc_pkg::ACT_DELIVER) ? dlv_hit : chk_hit;
  end

  assign pop = (state == S_IDLE) && ctl.valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (ctl.valid) state_next = S_SCAN;
      S_SCAN: begin
        if ((cur.action != rpcc_pkg::ACT_DELIVER && cur.action != rpcc_pkg::ACT_CHECK) ||
            (cur.action == rpcc_pkg::ACT_CHECK && cur.bad_range) ||
            hit_now || idx == SW'(rpcc_pkg::TableEntries - 1)) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_OUT;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ev    <= '0;
      drops <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        S_IDLE: begin
          cur   <= head;
          idx   <= '0;
          found <= 1'b0;
          hit   <= '0;
        end
        S_SCAN: begin
          if (hit_now && !found) begin
            found <= 1'b1;
            hit   <= idx;
          end
          if (idx != SW'(rpcc_pkg::TableEntries - 1)) idx <= idx + 1'b1;
        end
        S_EXEC: begin
          done           <= 1'b1;
          status         <= rpcc_pkg::ST_OK;
          matched_slot   <= '0;
          buffers_in_use <= '0;
          case (cur.action)
            rpcc_pkg::ACT_WRITE: if (slot_ok) begin
              ev[s] <= 1'b1;
              ekind[s] <= cur.kind_mask;
              eopt[s]  <= cur.options;
              elow[s]  <= cur.low_number;
              ehigh[s] <= cur.high_number;
              ehost[s] <= cur.host_addr;
              eaddr[s] <= cur.local_addr;
              eifid[s] <= cur.interface_id;
              ecap[s]  <= cur.buffer_count;
              eused[s] <= '0;
            end
            rpcc_pkg::ACT_FREE: if (slot_ok) begin
              ev[s]    <= 1'b0;
              eused[s] <= '0;
            end
            rpcc_pkg::ACT_DELIVER: begin
              if (!found) begin
                status <= rpcc_pkg::ST_NO_MATCH;
                drops  <= drops + 1'b1;
                buffers_in_use <= '0;
              end else begin
                matched_slot <= 4'(hit);
                if (cur.packet_flags[1] && !eopt[hit][1]) begin
                  status <= rpcc_pkg::ST_UNWANTED;
                  drops  <= drops + 1'b1;
                  buffers_in_use <= eused[hit];
                end else if (sum <= 9'(ecap[hit])) begin
                  eused[hit] <= sum[7:0];
                  buffers_in_use <= sum[7:0];
                end else begin
                  status <= rpcc_pkg::ST_NO_SPACE;
                  buffers_in_use <= eused[hit];
                end
              end
            end
            rpcc_pkg::ACT_CHECK: begin
              if (cur.bad_range) status <= rpcc_pkg::ST_BAD_RANGE;
              else if (found) status <= rpcc_pkg::ST_IN_USE;
            end
            rpcc_pkg::ACT_RELEASE: if (slot_ok && ev[s]) begin
              eused[s] <= (eused[s] > cur.buffer_count) ?
                          eused[s] - cur.buffer_count : 8'd0;
              buffers_in_use <= (eused[s] > cur.buffer_count) ?
                                eused[s] - cur.buffer_count : 8'd0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign drop_total = drops;

endmodule

FILE: src/raw_packet_connection_classifier_unit.sv
// ----------------------------------------------------------------------------
// raw_packet_connection_classifier_unit: connection table classifier
// Writes, frees, releases, checks and delivers against a sixteen-entry table.
// ----------------------------------------------------------------------------
// Usage:
//   Items are taken on start while busy is low; busy rises when the two-deep
//   queue in front of the table engine is full. Each item yields one result,
//   shown for one cycle with done high; the receiver cannot stall it.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always ready; index 0 is the reserved protocol, 1 the reserved link.
//   An item passes a load step, the scan, an execute step and the result
//   step. Deliver and check scan one entry a cycle and stop at the first hit
//   or the last of the sixteen entries; other actions and a check with a bad
//   range leave the scan at once. A new item is loaded only after the result.
//   Reset empties the table, the queue and the drop counter and restores
//   the reserved numbers to 6 and 155.
// ----------------------------------------------------------------------------
module raw_packet_connection_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [2:0]  action,
  input  logic [3:0]  slot,
  input  logic [1:0]  kind_mask,
  input  logic [1:0]  options,
  input  logic [7:0]  low_number,
  input  logic [7:0]  high_number,
  input  logic [31:0] host_addr,
  input  logic [31:0] peer_addr,
  input  logic [31:0] local_addr,
  input  logic [1:0]  packet_flags,
  input  logic [3:0]  interface_id,
  input  logic [7:0]  buffer_count,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  matched_slot,
  output logic [7:0]  buffers_in_use,
  output logic [15:0] drop_total
);

  logic            space, take, pop;
  rpcc_pkg::item_t fitem, head;
  rpcc_pkg::qctl_t ctl;

  assign busy      = !space;
  assign cfg_ready = 1'b1;

  rpcc_front u_front (
    .clk, .rst, .start, .space, .take, .cfg_valid, .cfg_index, .cfg_data,
    .action, .slot, .kind_mask, .options, .low_number, .high_number,
    .host_addr, .peer_addr, .local_addr, .packet_flags, .interface_id,
    .buffer_count, .item(fitem)
  );

  rpcc_queue u_queue (
    .clk, .rst, .push(take), .push_item(fitem), .space, .pop, .ctl, .head
  );

  rpcc_back u_back (
    .clk, .rst, .ctl, .head, .pop, .done, .status, .matched_slot,
    .buffers_in_use, .drop_total
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> ctl.valid) else $error("pop from empty queue");
  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    take |-> ctl.ready) else $error("push into full queue");
  a_drop_step: assert property (@(posedge clk) disable iff (rst)
    !done |=> ($stable(drop_total) || drop_total == $past(drop_total) + 16'd1))
    else $error("drop counter jumped");

endmodule
